/* hw/rtl/mcwn_pkg.sv */
// Shared types and constants for the maze cell weight navigator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mcwn_pkg;

  localparam int COORD_W  = 6;   // holds any coordinate plus one step past the grid
  localparam int WEIGHT_W = 7;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 24;
  localparam int OUT_PAD  = 7;

  localparam logic [WEIGHT_W-1:0] DEAD_MARK   = 7'd99;
  localparam logic [WEIGHT_W-1:0] WEIGHT_STEP = 7'd3;
  localparam logic [WEIGHT_W-1:0] WEIGHT_CAP  = 7'd98;

  // Absolute directions.
  localparam logic [2:0] DIR_N = 3'd1;
  localparam logic [2:0] DIR_E = 3'd2;
  localparam logic [2:0] DIR_S = 3'd3;
  localparam logic [2:0] DIR_W = 3'd4;

  // Move kinds.
  localparam logic [1:0] MOVE_FWD   = 2'd0;
  localparam logic [1:0] MOVE_RIGHT = 2'd1;
  localparam logic [1:0] MOVE_LEFT  = 2'd2;
  localparam logic [1:0] MOVE_UTURN = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 2'd2;

  // Memory access slots of one item.
  localparam logic [1:0] SEL_FWD   = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_LEFT  = 2'd2;
  localparam logic [1:0] SEL_CUR   = 2'd3;

  typedef struct packed {
    logic       clr_wr;
    logic       load_in;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       commit;
  } mcwn_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } mcwn_status_t;

endpackage

`default_nettype wire

/* hw/rtl/maze_cell_weight_navigator_core.sv */
// Maze cell weight navigator, top level: joins the sequencer and the datapath.
// A result word is registered at commit, which waits until the last one is taken.
// A new input word is taken only once the last one is committed; each word needs
// four reads through the single weight memory read port, a capture and a commit.
// Reset: synchronous; afterwards a clearing pass over all GRID_SIDE*GRID_SIDE cells
// loads the distance weights, during which no input word is taken.
`default_nettype none

module maze_cell_weight_navigator_core #(
  parameter int GRID_SIDE = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [mcwn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [mcwn_pkg::CFG_W-1:0]     cfg_data,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] forward_open, [1] right_open, [2] left_open, [7:3] zero
  input  wire [mcwn_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // [4:0] next_x, [9:5] next_y, [12:10] new_heading, [14:13] move_kind,
  // [15] marked_dead, [16] off_grid, [23:17] zero
  output logic [mcwn_pkg::OUT_W-1:0]    m_axis_tdata
);
  import mcwn_pkg::*;

  mcwn_cmd_t    cmd;
  mcwn_status_t status;

  mcwn_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd),
    .status        (status)
  );

  mcwn_datapath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_data       (s_axis_tdata),
    .cmd           (cmd),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/mcwn_ctrl.sv */
// Sequencer of the navigator: clearing pass, neighbour reads, commit.
// Depends on mcwn_pkg for the command and status structs.
`default_nettype none

module mcwn_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  output mcwn_pkg::mcwn_cmd_t   cmd,
  input  mcwn_pkg::mcwn_status_t status
);
  import mcwn_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RD0    = 3'd2;
  localparam logic [2:0] ST_RD1    = 3'd3;
  localparam logic [2:0] ST_RD2    = 3'd4;
  localparam logic [2:0] ST_RD3    = 3'd5;
  localparam logic [2:0] ST_CAP    = 3'd6;
  localparam logic [2:0] ST_COMMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Each read slot after the first also captures the data of the slot before it,
  // since the memory output is registered.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load_in   = s_axis_tvalid;
        if (s_axis_tvalid) state_next = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_FWD;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_RIGHT;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_FWD;
        state_next  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_LEFT;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_RIGHT;
        state_next  = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_CUR;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_LEFT;
        state_next  = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = SEL_CUR;
        state_next  = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/mcwn_datapath.sv */
// Datapath of the navigator: weight memory, position and heading, move choice,
// output register. Depends on mcwn_pkg; driven by mcwn_ctrl commands.
`default_nettype none

module mcwn_datapath #(
  parameter int GRID_SIDE = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [mcwn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [mcwn_pkg::CFG_W-1:0]        cfg_data,
  input  wire [mcwn_pkg::IN_W-1:0]         in_data,
  input  mcwn_pkg::mcwn_cmd_t              cmd,
  output mcwn_pkg::mcwn_status_t           status,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [mcwn_pkg::OUT_W-1:0]       m_axis_tdata
);
  import mcwn_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_SIDE);
  localparam int HALF  = GRID_SIDE / 2;
  localparam logic [COORD_W-1:0] SIDE_C = COORD_W'(GRID_SIDE);
  localparam logic [IW-1:0]      LAST_I = IW'(GRID_SIDE - 1);

  function automatic logic [COORD_W-1:0] step_x(logic [2:0] d, logic [COORD_W-1:0] x);
    logic [COORD_W-1:0] r;
    if (d == DIR_E) r = x + COORD_W'(1);
    else if (d == DIR_N || d == DIR_S) r = x;
    else r = x - COORD_W'(1);
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] step_y(logic [2:0] d, logic [COORD_W-1:0] y);
    logic [COORD_W-1:0] r;
    if (d == DIR_N) r = y - COORD_W'(1);
    else if (d == DIR_S) r = y + COORD_W'(1);
    else r = y;
    return r;
  endfunction

  // A step to column 0 fails the nonzero check; below that it wraps to a large value and fails the upper bound.
  function automatic logic in_grid(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    return (x != '0) && (x <= SIDE_C) && (y != '0) && (y <= SIDE_C);
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    logic [COORD_W-1:0] xm;
    logic [COORD_W-1:0] ym;
    xm = x - COORD_W'(1);
    ym = y - COORD_W'(1);
    return AW'(int'(ym) * GRID_SIDE + int'(xm));
  endfunction

  function automatic logic [WEIGHT_W-1:0] axis_dist(logic [IW-1:0] i);
    logic [WEIGHT_W-1:0] r;
    if (int'(i) < HALF) r = WEIGHT_W'(HALF - 1 - int'(i));
    else r = WEIGHT_W'(int'(i) - HALF);
    return r;
  endfunction

  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [WEIGHT_W-1:0] rd_data;

  logic [COORD_W-1:0]  pos_x;
  logic [COORD_W-1:0]  pos_y;
  logic [2:0]          heading;
  logic                fill;
  logic                in_f;
  logic                in_r;
  logic                in_l;
  logic [WEIGHT_W-1:0] wt [3];
  logic [WEIGHT_W-1:0] cur_wt;
  logic [IW-1:0]       clr_x;
  logic [IW-1:0]       clr_y;

  logic [1:0]          hb;
  logic [2:0]          dir [3];
  logic [2:0]          dir_u;
  logic [COORD_W-1:0]  nx [3];
  logic [COORD_W-1:0]  ny [3];
  logic [2:0]          open_v;
  logic                none_open;
  logic                multi_open;
  logic [1:0]          kind;
  logic [2:0]          nh;
  logic                fill_new;
  logic                cur_ok;
  logic [WEIGHT_W:0]   raised;
  logic [WEIGHT_W-1:0] upd_wt;
  logic [COORD_W-1:0]  tx;
  logic [COORD_W-1:0]  ty;
  logic                tgt_ok;
  logic [COORD_W-1:0]  new_x;
  logic [COORD_W-1:0]  new_y;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WEIGHT_W-1:0] wr_data;

  // Relative directions from the heading; out-of-range headings fold into 1..4.
  always_comb begin
    hb     = heading[1:0] + 2'd3;
    dir[0] = {1'b0, hb} + 3'd1;
    dir[1] = {1'b0, 2'(hb + 2'd1)} + 3'd1;
    dir[2] = {1'b0, 2'(hb + 2'd3)} + 3'd1;
    dir_u  = {1'b0, 2'(hb + 2'd2)} + 3'd1;
    for (int i = 0; i < 3; i++) begin
      nx[i] = step_x(dir[i], pos_x);
      ny[i] = step_y(dir[i], pos_y);
    end
    open_v[0] = in_f && in_grid(nx[0], ny[0]) && (wt[0] != DEAD_MARK);
    open_v[1] = in_r && in_grid(nx[1], ny[1]) && (wt[1] != DEAD_MARK);
    open_v[2] = in_l && in_grid(nx[2], ny[2]) && (wt[2] != DEAD_MARK);
    none_open  = (open_v == 3'b000);
    multi_open = (open_v[0] && open_v[1]) || (open_v[0] && open_v[2]) ||
                 (open_v[1] && open_v[2]);

    // Ties go to forward, then right.
    if (none_open) begin
      kind = MOVE_UTURN;
    end else if (open_v[0] && (!open_v[1] || wt[0] <= wt[1]) &&
                 (!open_v[2] || wt[0] <= wt[2])) begin
      kind = MOVE_FWD;
    end else if (open_v[1] && (!open_v[2] || wt[1] <= wt[2])) begin
      kind = MOVE_RIGHT;
    end else begin
      kind = MOVE_LEFT;
    end

    case (kind)
      MOVE_FWD:   nh = dir[0];
      MOVE_RIGHT: nh = dir[1];
      MOVE_LEFT:  nh = dir[2];
      default:    nh = dir_u;
    endcase

    if (none_open) fill_new = 1'b1;
    else if (multi_open) fill_new = 1'b0;
    else fill_new = fill;

    cur_ok = in_grid(pos_x, pos_y);
    raised = {1'b0, cur_wt} + {1'b0, WEIGHT_STEP};
    if (fill_new) upd_wt = DEAD_MARK;
    else if (raised > {1'b0, WEIGHT_CAP}) upd_wt = WEIGHT_CAP;
    else upd_wt = raised[WEIGHT_W-1:0];

    tx     = step_x(nh, pos_x);
    ty     = step_y(nh, pos_y);
    tgt_ok = in_grid(tx, ty);
    new_x  = tgt_ok ? tx : pos_x;
    new_y  = tgt_ok ? ty : pos_y;
  end

  // Off-grid cells are never used, so their reads fall back to entry zero.
  always_comb begin
    case (cmd.rd_sel)
      SEL_FWD:   rd_addr = in_grid(nx[0], ny[0]) ? cell_addr(nx[0], ny[0]) : '0;
      SEL_RIGHT: rd_addr = in_grid(nx[1], ny[1]) ? cell_addr(nx[1], ny[1]) : '0;
      SEL_LEFT:  rd_addr = in_grid(nx[2], ny[2]) ? cell_addr(nx[2], ny[2]) : '0;
      default:   rd_addr = cur_ok ? cell_addr(pos_x, pos_y) : '0;
    endcase
  end

  always_comb begin
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(int'(clr_y) * GRID_SIDE + int'(clr_x));
      wr_data = axis_dist(clr_y) + axis_dist(clr_x);
    end else begin
      wr_en   = cmd.commit && cur_ok;
      wr_addr = cell_addr(pos_x, pos_y);
      wr_data = upd_wt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_f <= in_data[0];
      in_r <= in_data[1];
      in_l <= in_data[2];
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        SEL_FWD:   wt[0]  <= rd_data;
        SEL_RIGHT: wt[1]  <= rd_data;
        SEL_LEFT:  wt[2]  <= rd_data;
        default:   cur_wt <= rd_data;
      endcase
    end
  end

  // Clearing pass after reset walks the grid row by row.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_x <= '0;
      clr_y <= '0;
    end else if (cmd.clr_wr) begin
      if (clr_x == LAST_I) begin
        clr_x <= '0;
        clr_y <= (clr_y == LAST_I) ? '0 : clr_y + IW'(1);
      end else begin
        clr_x <= clr_x + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= COORD_W'(1);
      pos_y   <= COORD_W'(16);
      heading <= DIR_N;
      fill    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        pos_x   <= new_x;
        pos_y   <= new_y;
        heading <= nh;
        fill    <= fill_new;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_HEADING: heading <= cfg_data[2:0];
          REG_START_X:       pos_x   <= {1'b0, cfg_data};
          REG_START_Y:       pos_y   <= {1'b0, cfg_data};
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_axis_tdata <= {{OUT_PAD{1'b0}}, !tgt_ok, fill_new, kind, nh,
                       new_y[4:0], new_x[4:0]};
    end
  end

  assign status.clr_last = (clr_x == LAST_I) && (clr_y == LAST_I);
  assign status.out_free = !m_axis_tvalid || m_axis_tready;

endmodule

`default_nettype wire

/* tb/mcwn_move_checker.sv */
`timescale 1ns / 1ps
// Result checker for the maze cell weight navigator: follows the config writes
// and both streams, keeps its own grid and robot, and compares each result word.
// Depends on mcwn_pkg for widths, directions, move kinds and register indexes.
module mcwn_move_checker #(
  parameter int GRID_SIDE = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [mcwn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [mcwn_pkg::CFG_W-1:0]     cfg_data,
  input  wire                           s_axis_tvalid,
  input  wire                           s_axis_tready,
  input  wire [mcwn_pkg::IN_W-1:0]      s_axis_tdata,
  input  wire                           m_axis_tvalid,
  input  wire                           m_axis_tready,
  input  wire [mcwn_pkg::OUT_W-1:0]     m_axis_tdata,
  output int                            mismatches,
  output int                            pending
);
  import mcwn_pkg::*;

  localparam logic [4:0] START_X_RST = 5'd1;
  localparam logic [4:0] START_Y_RST = 5'd16;

  typedef struct packed {
    logic [4:0] nx;
    logic [4:0] ny;
    logic [2:0] hd;
    logic [1:0] kind;
    logic       dead;
    logic       off;
  } nav_move_t;

  logic [WEIGHT_W-1:0] weight_map [1:GRID_SIDE][1:GRID_SIDE];
  // One bit wider than the output fields, so a coordinate of 32 on the
  // largest grid is kept while only its low five bits are reported.
  logic [5:0]          pos_x;
  logic [5:0]          pos_y;
  logic [2:0]          heading;
  logic                dead_fill;
  nav_move_t           moves_due[$];

  function automatic int axis_dist(int c);
    int h;
    h = GRID_SIDE / 2;
    return (c <= h) ? h - c : c - (h + 1);
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 1 && x <= GRID_SIDE && y >= 1 && y <= GRID_SIDE;
  endfunction

  // Cell next to the robot in absolute direction d.
  function automatic void neighbour(int d, output int nx, output int ny);
    nx = int'(pos_x);
    ny = int'(pos_y);
    case (d)
      DIR_N:   ny = ny - 1;
      DIR_E:   nx = nx + 1;
      DIR_S:   ny = ny + 1;
      default: nx = nx - 1;
    endcase
  endfunction

  // Chooses the move for one sensor word, updates the grid and robot, and
  // returns the result word that the block should send.
  task automatic advance_robot(input logic [2:0] flags, output nav_move_t mv);
    int h, cnt, kind, nh, nx, ny, v;
    int dir [3];
    int wt [3];
    bit open_dir [3];
    bit off;
    // Headings outside 1..4 wrap around, so 0 acts as west.
    h = ((int'(heading) + 3) % 4) + 1;
    dir[0] = h;
    dir[1] = (h % 4) + 1;
    dir[2] = ((h + 2) % 4) + 1;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      neighbour(dir[i], nx, ny);
      if (on_grid(nx, ny)) begin
        wt[i] = int'(weight_map[ny][nx]);
        open_dir[i] = flags[i] && (wt[i] != int'(DEAD_MARK));
      end else begin
        wt[i] = int'(DEAD_MARK);
        open_dir[i] = 1'b0;
      end
      if (open_dir[i]) cnt++;
    end

    if (cnt == 0) begin
      kind = MOVE_UTURN;
      nh = ((h + 1) % 4) + 1;
      dead_fill = 1'b1;
    end else begin
      if (open_dir[0] && (!open_dir[1] || wt[0] <= wt[1]) &&
          (!open_dir[2] || wt[0] <= wt[2]))
        kind = MOVE_FWD;
      else if (open_dir[1] && (!open_dir[2] || wt[1] <= wt[2]))
        kind = MOVE_RIGHT;
      else
        kind = MOVE_LEFT;
      nh = dir[kind];
      // A single way out keeps the fill going along a dead-end corridor.
      if (cnt >= 2) dead_fill = 1'b0;
    end

    if (on_grid(int'(pos_x), int'(pos_y))) begin
      if (dead_fill) begin
        weight_map[pos_y][pos_x] = DEAD_MARK;
      end else begin
        v = int'(weight_map[pos_y][pos_x]) + int'(WEIGHT_STEP);
        weight_map[pos_y][pos_x] = (v > int'(WEIGHT_CAP)) ? WEIGHT_CAP : WEIGHT_W'(v);
      end
    end

    heading = 3'(nh);
    neighbour(nh, nx, ny);
    off = 1'b0;
    if (on_grid(nx, ny)) begin
      pos_x = 6'(nx);
      pos_y = 6'(ny);
    end else begin
      off = 1'b1;
    end

    mv.nx   = pos_x[4:0];
    mv.ny   = pos_y[4:0];
    mv.hd   = 3'(nh);
    mv.kind = 2'(kind);
    mv.dead = dead_fill;
    mv.off  = off;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    nav_move_t mv;
    if (rst) begin
      for (int y = 1; y <= GRID_SIDE; y++)
        for (int x = 1; x <= GRID_SIDE; x++)
          weight_map[y][x] = WEIGHT_W'(axis_dist(y) + axis_dist(x));
      pos_x = {1'b0, START_X_RST};
      pos_y = {1'b0, START_Y_RST};
      heading = DIR_N;
      dead_fill = 1'b0;
      moves_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_HEADING: heading = cfg_data[2:0];
          REG_START_X:       pos_x = {1'b0, cfg_data[4:0]};
          REG_START_Y:       pos_y = {1'b0, cfg_data[4:0]};
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_robot(s_axis_tdata[2:0], mv);
        moves_due.push_back(mv);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (moves_due.size() == 0) begin
          $error("result word arrived with no move predicted");
          mismatches++;
        end else begin
          mv = moves_due.pop_front();
          check_field("next_x", mv.nx, m_axis_tdata[4:0]);
          check_field("next_y", mv.ny, m_axis_tdata[9:5]);
          check_field("new_heading", mv.hd, m_axis_tdata[12:10]);
          check_field("move_kind", mv.kind, m_axis_tdata[14:13]);
          check_field("marked_dead", mv.dead, m_axis_tdata[15]);
          check_field("off_grid", mv.off, m_axis_tdata[16]);
        end
      end
    end
    pending = moves_due.size();
  end

endmodule

/* tb/maze_cell_weight_navigator_core_tb.sv */
`timescale 1ns / 1ps
// Top of the navigator testbench: clock, reset, config writes, sensor words and
// result back-pressure. Depends on mcwn_pkg, the core and mcwn_move_checker.
module maze_cell_weight_navigator_core_tb;
  import mcwn_pkg::*;

  localparam int GRID_SIDE = 16;
  localparam int LIMIT     = 500000;
  localparam int PHASES    = 9;
  localparam int PHASE_LEN = 59;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_HEADING;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;

  int mismatches;
  int pending;
  int results_seen = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  always #2 clk = ~clk;

  maze_cell_weight_navigator_core #(.GRID_SIDE(GRID_SIDE)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  mcwn_move_checker #(.GRID_SIDE(GRID_SIDE)) checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;

  // Entered and left at a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_start(input int hd, input int x, input int y);
    write_reg(REG_START_HEADING, hd);
    write_reg(REG_START_X, x);
    write_reg(REG_START_Y, y);
  endtask

  // Offers one sensor word after an optional gap and returns once it is taken.
  task automatic send_word(input logic [2:0] flags);
    int gap, r;
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W-3){1'b0}}, flags};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  // Result side: short random stalls, a few long ones, and one long hold-off
  // that lets the core back up into its input.
  initial begin
    int stall_left, r;
    bit pressed;
    stall_left = 0;
    pressed = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!pressed && results_seen >= 150) begin
        pressed = 1'b1;
        stall_left = 399;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset position, bottom-left corner facing north: every wall pattern, with two
    // dead ends back to back near the start so the fill flag is set and carried.
    send_word(3'b111);
    send_word(3'b000);
    send_word(3'b000);
    send_word(3'b001);
    send_word(3'b010);
    send_word(3'b100);
    send_word(3'b011);
    send_word(3'b101);
    send_word(3'b110);
    send_word(3'b111);
    send_word(3'b000);
    settle();

    // Heading 0 reads as west, starting in the top-right corner.
    load_start(0, GRID_SIDE, 1);
    send_word(3'b111);
    send_word(3'b000);
    send_word(3'b000);
    settle();

    // Heading 7 reads as south, starting one column left of the grid.
    load_start(7, 0, 8);
    send_word(3'b111);
    send_word(3'b010);
    settle();

    // Far off the grid: nothing is open and the position stays put.
    load_start(5, 31, 31);
    send_word(3'b111);
    send_word(3'b000);
    settle();

    // Heading 6 reads as east, starting one row above the grid.
    load_start(6, 8, 0);
    send_word(3'b111);
    send_word(3'b111);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      int hd, x, y, pct;
      logic [2:0] flags;
      if (p == 0) begin
        hd = DIR_W;
        x = GRID_SIDE;
        y = GRID_SIDE;
      end else if (p == 1) begin
        hd = DIR_N;
        x = 1;
        y = 1;
      end else begin
        hd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      end
      calm = (p % 3 == 2);
      load_start(hd, x, y);
      pct = $urandom_range(45, 95);
      repeat (PHASE_LEN) begin
        if ($urandom_range(0, 9) == 0) begin
          flags = 3'($urandom_range(0, 7));
        end else begin
          for (int b = 0; b < 3; b++) flags[b] = ($urandom_range(0, 99) < pct);
        end
        send_word(flags);
      end
      settle();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
